// ----- sv/cdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and width constants for the circular deque: operation codes,
// status codes and the sequencer states.
// ----------------------------------------------------------------------------
package cdq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FETCH = 2'd1,
        S_DONE  = 2'd2
    } state_t;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 4;

endpackage

// ----- sv/cdq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/circular_deque.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue over a circular RAM of DEPTH signed words, with front
// and rear indices, an element count and cached copies of both end values.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, operation, data_in    | into block
//  out     | out_valid, out_ready, popped_value,       | out of block
//          | status, front_value, rear_value,          |
//          | element_count, is_empty, is_full          |
//
//  Sequence: a push or a rejected operation goes from accept to the done
//  state and then to the output register; a successful pop that leaves
//  elements passes the fetch state first, since the new end value comes back registered from the single RAM read port.
//  One transaction is in flight at a time; a new one is taken in idle.
//  Reset: indices and count go to zero, the deque is empty; the RAM has no
//  reset and only slots that were written are ever read.
//  Stalls: the finished result waits in the sequencer until the output
//  register frees, while the previous result is held on the port.
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic signed [31:0] data_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] popped_value,
    output logic [1:0]         status,
    output logic signed [31:0] front_value,
    output logic signed [31:0] rear_value,
    output logic [3:0]         element_count,
    output logic               is_empty,
    output logic               is_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer
    cdq_pkg::state_t state_reg, state_next;

    // Deque state
    logic [AW-1:0] front_idx_reg, front_idx_next;
    logic [AW-1:0] rear_idx_reg, rear_idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          empty_reg, empty_next;

    // Cached end values, valid whenever the deque is not empty, except for the end being refilled in the fetch state
    logic signed [31:0] front_val_reg, front_val_next;
    logic signed [31:0] rear_val_reg, rear_val_next;

    // Pending result of the transaction in flight
    logic signed [31:0] popped_reg, popped_next;
    cdq_pkg::status_t   status_reg, status_next;
    logic               fetch_front_reg, fetch_front_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_popped_reg;
    logic [1:0]         out_status_reg;
    logic signed [31:0] out_front_reg;
    logic signed [31:0] out_rear_reg;
    logic [3:0]         out_count_reg;
    logic               out_empty_reg;
    logic               out_full_reg;

    // RAM port
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [31:0]   mem_rd_data;

    logic          accept;
    logic          need_fetch;
    logic          out_load;
    logic          full;
    cdq_pkg::op_t  op;

    logic [AW-1:0] front_inc, front_dec, rear_inc, rear_dec;

    assign op     = cdq_pkg::op_t'(operation);
    assign accept = in_valid && in_ready;
    assign full   = (count_reg == CW'(DEPTH));

    // Wrap the indices around the ring
    assign front_inc = (front_idx_reg == AW'(DEPTH - 1)) ? '0 : front_idx_reg + AW'(1);
    assign front_dec = (front_idx_reg == '0) ? AW'(DEPTH - 1) : front_idx_reg - AW'(1);
    assign rear_inc  = (rear_idx_reg == AW'(DEPTH - 1)) ? '0 : rear_idx_reg + AW'(1);
    assign rear_dec  = (rear_idx_reg == '0) ? AW'(DEPTH - 1) : rear_idx_reg - AW'(1);

    cdq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (data_in),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // ------------------------------------------------------------------
    // Datapath: apply the operation at accept, refill a cached end value
    // from the RAM in the fetch state.
    // ------------------------------------------------------------------
    always_comb
    begin
        front_idx_next   = front_idx_reg;
        rear_idx_next    = rear_idx_reg;
        count_next       = count_reg;
        empty_next       = empty_reg;
        front_val_next   = front_val_reg;
        rear_val_next    = rear_val_reg;
        popped_next      = popped_reg;
        status_next      = status_reg;
        fetch_front_next = fetch_front_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = '0;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = '0;
        need_fetch       = 1'b0;

        if (accept)
        begin
            popped_next = '0;
            status_next = cdq_pkg::ST_DONE;
            case (op)
                cdq_pkg::OP_PUSH_FRONT,
                cdq_pkg::OP_PUSH_REAR:
                begin
                    if (full)
                    begin
                        status_next = cdq_pkg::ST_FULL;
                    end
                    else if (empty_reg)
                    begin
                        // First element: both ends land on slot zero
                        front_idx_next = '0;
                        rear_idx_next  = '0;
                        empty_next     = 1'b0;
                        count_next     = CW'(1);
                        front_val_next = data_in;
                        rear_val_next  = data_in;
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = '0;
                    end
                    else if (op == cdq_pkg::OP_PUSH_FRONT)
                    begin
                        front_idx_next = front_dec;
                        count_next     = count_reg + CW'(1);
                        front_val_next = data_in;
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = front_dec;
                    end
                    else
                    begin
                        rear_idx_next  = rear_inc;
                        count_next     = count_reg + CW'(1);
                        rear_val_next  = data_in;
                        mem_wr_en      = 1'b1;
                        mem_wr_addr    = rear_inc;
                    end
                end
                cdq_pkg::OP_POP_FRONT,
                cdq_pkg::OP_POP_REAR:
                begin
                    if (empty_reg)
                    begin
                        status_next = cdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        popped_next = (op == cdq_pkg::OP_POP_FRONT) ? front_val_reg
                                                                    : rear_val_reg;
                        count_next  = count_reg - CW'(1);
                        if (front_idx_reg == rear_idx_reg)
                        begin
                            // Last element gone: park both indices at zero
                            empty_next     = 1'b1;
                            front_idx_next = '0;
                            rear_idx_next  = '0;
                        end
                        else if (op == cdq_pkg::OP_POP_FRONT)
                        begin
                            front_idx_next   = front_inc;
                            fetch_front_next = 1'b1;
                            mem_rd_en        = 1'b1;
                            mem_rd_addr      = front_inc;
                            need_fetch       = 1'b1;
                        end
                        else
                        begin
                            rear_idx_next    = rear_dec;
                            fetch_front_next = 1'b0;
                            mem_rd_en        = 1'b1;
                            mem_rd_addr      = rear_dec;
                            need_fetch       = 1'b1;
                        end
                    end
                end
                default:
                begin
                    status_next = cdq_pkg::ST_DONE;
                end
            endcase
        end

        if (state_reg == cdq_pkg::S_FETCH)
        begin
            if (fetch_front_reg)
            begin
                front_val_next = mem_rd_data;
            end
            else
            begin
                rear_val_next = mem_rd_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_fetch ? cdq_pkg::S_FETCH : cdq_pkg::S_DONE;
                end
            end
            cdq_pkg::S_FETCH:
            begin
                state_next = cdq_pkg::S_DONE;
            end
            cdq_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = cdq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cdq_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            cdq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            cdq_pkg::S_FETCH:
            begin
                in_ready = 1'b0;
            end
            cdq_pkg::S_DONE:
            begin
                // Hand over once the output register is free or draining
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdq_pkg::S_IDLE;
            front_idx_reg <= '0;
            rear_idx_reg  <= '0;
            count_reg     <= '0;
            empty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_idx_reg <= front_idx_next;
            rear_idx_reg  <= rear_idx_next;
            count_reg     <= count_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: cached ends, pending result and output register
    always_ff @(posedge clk)
    begin
        front_val_reg   <= front_val_next;
        rear_val_reg    <= rear_val_next;
        popped_reg      <= popped_next;
        status_reg      <= status_next;
        fetch_front_reg <= fetch_front_next;
        if (out_load)
        begin
            out_popped_reg <= popped_reg;
            out_status_reg <= status_reg;
            out_front_reg  <= empty_reg ? '0 : front_val_reg;
            out_rear_reg   <= empty_reg ? '0 : rear_val_reg;
            out_count_reg  <= 4'(count_reg);
            out_empty_reg  <= empty_reg;
            out_full_reg   <= full;
        end
    end

    assign out_valid     = out_valid_reg;
    assign popped_value  = out_popped_reg;
    assign status        = out_status_reg;
    assign front_value   = out_front_reg;
    assign rear_value    = out_rear_reg;
    assign element_count = out_count_reg;
    assign is_empty      = out_empty_reg;
    assign is_full       = out_full_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond depth");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg == (count_reg == '0))
        else $error("empty flag and count disagree");

    a_empty_parked: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (front_idx_reg == '0 && rear_idx_reg == '0))
        else $error("indices not parked while empty");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == cdq_pkg::S_DONE))
        else $error("result presented outside the done state");

    a_fetch_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cdq_pkg::S_FETCH |-> $past(mem_rd_en))
        else $error("fetch state without a RAM read");

endmodule
